// File: rtl/core/sds_pkg.sv
// Shared types and constants of the SCAN disk scheduler.
// No dependencies; imported by every module of the block.
`default_nettype none

package sds_pkg;

    localparam int DEF_MAX_REQUESTS = 16;
    localparam int DEF_TRACK_BITS   = 16;

    // Width of the running head movement total.
    localparam int MOVE_W = 21;

    // Configuration register indexes.
    localparam int REG_IDX_W = 2;
    localparam logic [REG_IDX_W-1:0] REG_HEAD_TRACK = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_LOW_END    = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_HIGH_END   = 2'd2;

    // Front to back handoff: a finished, sorted batch waits in the front.
    typedef struct packed {
        logic valid;
        logic dropped;
    } handoff_ctl_t;

endpackage

`default_nettype wire

// File: rtl/core/sds_front.sv
// Front end: accepts track requests into an insertion-sorting cell chain.
// Depends on sds_pkg.
`default_nettype none

module sds_front
    import sds_pkg::*;
#(
    parameter int MAX_REQUESTS = DEF_MAX_REQUESTS,
    parameter int TRACK_BITS   = DEF_TRACK_BITS,
    localparam int CNTW        = $clog2(MAX_REQUESTS + 1)
)
(
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    push,
    input  wire logic [TRACK_BITS-1:0]                   track,
    input  wire logic                                    last_request,
    input  wire logic [TRACK_BITS-1:0]                   head_track,
    input  wire logic                                    take,
    output logic                                         full,
    output handoff_ctl_t                                 ctl,
    output logic [MAX_REQUESTS-1:0][TRACK_BITS-1:0]      chain,
    output logic [CNTW-1:0]                              count,
    output logic [CNTW-1:0]                              lt_count,
    output logic [CNTW-1:0]                              le_count
);

    logic [MAX_REQUESTS-1:0][TRACK_BITS-1:0] chain_reg;
    logic [MAX_REQUESTS-1:0][TRACK_BITS-1:0] chain_next;
    logic [MAX_REQUESTS-1:0]                 keep;
    logic [CNTW-1:0]                         cnt_reg;
    logic [CNTW-1:0]                         lt_reg;
    logic [CNTW-1:0]                         le_reg;
    logic                                    drop_reg;
    logic                                    done_reg;
    logic                                    accept;
    logic                                    store;

    assign accept = push && !done_reg;
    assign store  = accept && (cnt_reg != CNTW'(MAX_REQUESTS));

    // Each cell keeps its value, takes the new track, or takes its left neighbor.
    always_comb
    begin
        for (int i = 0; i < MAX_REQUESTS; i++)
        begin
            keep[i] = (CNTW'(i) < cnt_reg) && (chain_reg[i] <= track);
        end
        for (int i = 0; i < MAX_REQUESTS; i++)
        begin
            if (keep[i])
            begin
                chain_next[i] = chain_reg[i];
            end
            else if (i == 0)
            begin
                chain_next[i] = track;
            end
            else if (keep[i-1])
            begin
                chain_next[i] = track;
            end
            else
            begin
                chain_next[i] = chain_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (store)
        begin
            chain_reg <= chain_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            lt_reg   <= '0;
            le_reg   <= '0;
            drop_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (take)
        begin
            cnt_reg  <= '0;
            lt_reg   <= '0;
            le_reg   <= '0;
            drop_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (store)
            begin
                cnt_reg <= cnt_reg + CNTW'(1);
                if (track < head_track)
                begin
                    lt_reg <= lt_reg + CNTW'(1);
                end
                if (track <= head_track)
                begin
                    le_reg <= le_reg + CNTW'(1);
                end
            end
            else
            begin
                drop_reg <= 1'b1;
            end
            if (last_request)
            begin
                done_reg <= 1'b1;
            end
        end
    end

    assign full        = done_reg;
    assign ctl.valid   = done_reg;
    assign ctl.dropped = drop_reg;
    assign chain       = chain_reg;
    assign count       = cnt_reg;
    assign lt_count    = lt_reg;
    assign le_count    = le_reg;

endmodule

`default_nettype wire

// File: rtl/core/sds_back.sv
// Back end: merges head and disk ends into the sorted batch, then walks it
// in SCAN order into the result register. Depends on sds_pkg.
`default_nettype none

module sds_back
    import sds_pkg::*;
#(
    parameter int MAX_REQUESTS = DEF_MAX_REQUESTS,
    parameter int TRACK_BITS   = DEF_TRACK_BITS,
    localparam int CNTW        = $clog2(MAX_REQUESTS + 1)
)
(
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire handoff_ctl_t                            ctl,
    input  wire logic [MAX_REQUESTS-1:0][TRACK_BITS-1:0] chain,
    input  wire logic [CNTW-1:0]                         count,
    input  wire logic [CNTW-1:0]                         lt_count,
    input  wire logic [CNTW-1:0]                         le_count,
    input  wire logic [TRACK_BITS-1:0]                   head_track,
    input  wire logic [TRACK_BITS-1:0]                   low_end,
    input  wire logic [TRACK_BITS-1:0]                   high_end,
    input  wire logic                                    pop,
    output logic                                         take,
    output logic                                         empty,
    output logic [TRACK_BITS-1:0]                        position,
    output logic [MOVE_W-1:0]                            movement_total,
    output logic                                         overflow,
    output logic                                         final_res
);

    localparam int LIST_LEN = MAX_REQUESTS + 3;
    localparam int IDXW     = $clog2(LIST_LEN);
    localparam int LENW     = $clog2(LIST_LEN + 1);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_INS  = 4'b0010,
        ST_EDGE = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;

    state_t                                  state_reg, state_next;
    logic [LIST_LEN-1:0][TRACK_BITS-1:0]     list_reg, list_next;
    logic [LIST_LEN-1:0][TRACK_BITS-1:0]     list_ins;
    logic [LIST_LEN-1:0][TRACK_BITS-1:0]     list_load;
    logic [LIST_LEN-1:0]                     keep;
    logic [LENW-1:0]                         len_reg, len_next;
    logic [1:0]                              sub_reg, sub_next;
    logic [CNTW-1:0]                         n_reg, n_next;
    logic [CNTW-1:0]                         lt_reg, lt_next;
    logic [CNTW-1:0]                         le_reg, le_next;
    logic                                    drop_reg, drop_next;
    logic                                    left_reg, left_next;
    logic                                    phase_b_reg, phase_b_next;
    logic [IDXW-1:0]                         idx_reg, idx_next;
    logic [IDXW-1:0]                         hp_reg, hp_next;
    logic [IDXW-1:0]                         remain_reg, remain_next;
    logic                                    first_reg, first_next;
    logic                                    out_v_reg, out_v_next;
    logic [TRACK_BITS-1:0]                   pos_reg;
    logic [MOVE_W-1:0]                       tot_reg;
    logic                                    ovf_reg;
    logic                                    fin_reg;

    logic [TRACK_BITS-1:0]                   ins_val;
    logic [IDXW-1:0]                         rd_idx;
    logic [TRACK_BITS-1:0]                   rd_val;
    logic [IDXW-1:0]                         top;
    logic [IDXW-1:0]                         run_end;
    logic [IDXW-1:0]                         run_start;
    logic [TRACK_BITS-1:0]                   dist_left;
    logic [TRACK_BITS-1:0]                   dist_right;
    logic [TRACK_BITS-1:0]                   diff;
    logic [MOVE_W-1:0]                       total_new;
    logic                                    emit;

    assign top = IDXW'(n_reg) + IDXW'(2);

    always_comb
    begin
        case (sub_reg)
            2'd0:    ins_val = head_track;
            2'd1:    ins_val = low_end;
            default: ins_val = high_end;
        endcase
    end

    // Insert one value into the sorted list, and load the front's chain.
    always_comb
    begin
        for (int i = 0; i < LIST_LEN; i++)
        begin
            keep[i] = (LENW'(i) < len_reg) && (list_reg[i] <= ins_val);
        end
        for (int i = 0; i < LIST_LEN; i++)
        begin
            if (keep[i])
            begin
                list_ins[i] = list_reg[i];
            end
            else if (i == 0)
            begin
                list_ins[i] = ins_val;
            end
            else if (keep[i-1])
            begin
                list_ins[i] = ins_val;
            end
            else
            begin
                list_ins[i] = list_reg[i-1];
            end
            if (i < MAX_REQUESTS)
            begin
                list_load[i] = chain[i];
            end
            else
            begin
                list_load[i] = '0;
            end
        end
    end

    // Last index of the head value below the top, from the front's counts.
    always_comb
    begin
        run_end   = IDXW'(le_reg) + IDXW'(low_end <= head_track)
                  + IDXW'(high_end <= head_track);
        run_start = IDXW'(lt_reg) + IDXW'(low_end < head_track)
                  + IDXW'(high_end < head_track);
        if (run_end < top)
        begin
            hp_next = run_end;
        end
        else if (run_start < top)
        begin
            hp_next = top - IDXW'(1);
        end
        else
        begin
            hp_next = top;
        end
    end

    assign rd_idx     = (state_reg == ST_EDGE) ? top : idx_reg;
    assign rd_val     = list_reg[rd_idx];
    assign dist_left  = head_track - list_reg[0];
    assign dist_right = rd_val - head_track;
    assign diff       = (rd_val > pos_reg) ? (rd_val - pos_reg) : (pos_reg - rd_val);
    assign total_new  = first_reg ? '0 : (tot_reg + MOVE_W'(diff));
    assign emit       = (state_reg == ST_EMIT) && (!out_v_reg || pop);

    always_comb
    begin
        state_next   = state_reg;
        list_next    = list_reg;
        len_next     = len_reg;
        sub_next     = sub_reg;
        n_next       = n_reg;
        lt_next      = lt_reg;
        le_next      = le_reg;
        drop_next    = drop_reg;
        left_next    = left_reg;
        phase_b_next = phase_b_reg;
        idx_next     = idx_reg;
        remain_next  = remain_reg;
        first_next   = first_reg;
        take         = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (ctl.valid)
                begin
                    take       = 1'b1;
                    list_next  = list_load;
                    len_next   = LENW'(count);
                    n_next     = count;
                    lt_next    = lt_count;
                    le_next    = le_count;
                    drop_next  = ctl.dropped;
                    sub_next   = 2'd0;
                    state_next = ST_INS;
                end
            end
            ST_INS:
            begin
                list_next = list_ins;
                len_next  = len_reg + LENW'(1);
                sub_next  = sub_reg + 2'd1;
                if (sub_reg == 2'd2)
                begin
                    state_next = ST_EDGE;
                end
            end
            ST_EDGE:
            begin
                left_next    = dist_left < dist_right;
                idx_next     = hp_reg;
                phase_b_next = 1'b0;
                remain_next  = top;
                first_next   = 1'b1;
                state_next   = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (emit)
                begin
                    first_next  = 1'b0;
                    remain_next = remain_reg - IDXW'(1);
                    // Downward sweep first when the low end is closer.
                    if (left_reg)
                    begin
                        if (phase_b_reg)
                        begin
                            idx_next = idx_reg + IDXW'(1);
                        end
                        else if (idx_reg == '0)
                        begin
                            phase_b_next = 1'b1;
                            idx_next     = hp_reg + IDXW'(1);
                        end
                        else
                        begin
                            idx_next = idx_reg - IDXW'(1);
                        end
                    end
                    else
                    begin
                        if (phase_b_reg)
                        begin
                            idx_next = idx_reg - IDXW'(1);
                        end
                        else if (idx_reg == top)
                        begin
                            phase_b_next = 1'b1;
                            idx_next     = hp_reg - IDXW'(1);
                        end
                        else
                        begin
                            idx_next = idx_reg + IDXW'(1);
                        end
                    end
                    if (remain_reg == IDXW'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_v_next = emit ? 1'b1 : (pop ? 1'b0 : out_v_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            out_v_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_v_reg <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        list_reg    <= list_next;
        len_reg     <= len_next;
        sub_reg     <= sub_next;
        n_reg       <= n_next;
        lt_reg      <= lt_next;
        le_reg      <= le_next;
        drop_reg    <= drop_next;
        left_reg    <= left_next;
        phase_b_reg <= phase_b_next;
        idx_reg     <= idx_next;
        remain_reg  <= remain_next;
        first_reg   <= first_next;
        if (state_reg == ST_INS)
        begin
            hp_reg <= hp_next;
        end
        if (emit)
        begin
            pos_reg <= rd_val;
            tot_reg <= total_new;
            ovf_reg <= drop_reg;
            fin_reg <= (remain_reg == IDXW'(1));
        end
    end

    assign empty          = !out_v_reg;
    assign position       = pos_reg;
    assign movement_total = tot_reg;
    assign overflow       = ovf_reg;
    assign final_res      = fin_reg;

endmodule

`default_nettype wire

// File: rtl/core/scan_disk_scheduler_unit.sv
// Top level of the SCAN disk scheduler: configuration registers, front and back.
// Depends on sds_pkg, sds_front and sds_back.
`default_nettype none

// Usage:
// - Input queue: drive track and last_request, raise push; a request is taken
//   at a clock edge with push high and full low. Requests stream in at one per
//   cycle while full is low; a batch ends with the request marked last_request.
// - Each request enters a sorted cell chain as it arrives. Requests beyond
//   MAX_REQUESTS are dropped and the batch's results carry overflow.
// - Once the batch is complete, full stays high until the back end takes it.
//   Then the back end merges head_track, low_end and high_end into the list,
//   one after another, and then chooses the sweep direction.
// - Result queue: while empty is low, position, movement_total, overflow and
//   final_res show the oldest result; pop takes it. A batch of n stored
//   requests gives n+2 results at up to one per cycle, the first once the
//   sweep direction is chosen; final_res marks the last.
// - A stalled receiver holds the back end; the front keeps taking requests
//   of the next batch meanwhile, until that batch is complete.
// - Reset clears both queues and loads head 0, low end 0, high end 65535.
//   Write registers (wr_en, wr_index, wr_data) only while no batch is pending.

module scan_disk_scheduler_unit
    import sds_pkg::*;
#(
    parameter int MAX_REQUESTS = DEF_MAX_REQUESTS,
    parameter int TRACK_BITS   = DEF_TRACK_BITS
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  wr_en,
    input  wire logic [REG_IDX_W-1:0]  wr_index,
    input  wire logic [TRACK_BITS-1:0] wr_data,
    input  wire logic                  push,
    output logic                       full,
    input  wire logic [TRACK_BITS-1:0] track,
    input  wire logic                  last_request,
    output logic                       empty,
    input  wire logic                  pop,
    output logic [TRACK_BITS-1:0]      position,
    output logic [MOVE_W-1:0]          movement_total,
    output logic                       overflow,
    output logic                       final_res
);

    localparam int CNTW = $clog2(MAX_REQUESTS + 1);

    logic [TRACK_BITS-1:0]                   head_reg;
    logic [TRACK_BITS-1:0]                   low_reg;
    logic [TRACK_BITS-1:0]                   high_reg;
    handoff_ctl_t                            ctl;
    logic                                    take;
    logic [MAX_REQUESTS-1:0][TRACK_BITS-1:0] chain;
    logic [CNTW-1:0]                         count;
    logic [CNTW-1:0]                         lt_count;
    logic [CNTW-1:0]                         le_count;

    // Configuration registers; writes to an unused index are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            low_reg  <= '0;
            high_reg <= TRACK_BITS'(32'hFFFF);
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_HEAD_TRACK: head_reg <= wr_data;
                REG_LOW_END:    low_reg  <= wr_data;
                REG_HIGH_END:   high_reg <= wr_data;
                default:        ;
            endcase
        end
    end

    sds_front #(
        .MAX_REQUESTS (MAX_REQUESTS),
        .TRACK_BITS   (TRACK_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .track        (track),
        .last_request (last_request),
        .head_track   (head_reg),
        .take         (take),
        .full         (full),
        .ctl          (ctl),
        .chain        (chain),
        .count        (count),
        .lt_count     (lt_count),
        .le_count     (le_count)
    );

    sds_back #(
        .MAX_REQUESTS (MAX_REQUESTS),
        .TRACK_BITS   (TRACK_BITS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctl            (ctl),
        .chain          (chain),
        .count          (count),
        .lt_count       (lt_count),
        .le_count       (le_count),
        .head_track     (head_reg),
        .low_end        (low_reg),
        .high_end       (high_reg),
        .pop            (pop),
        .take           (take),
        .empty          (empty),
        .position       (position),
        .movement_total (movement_total),
        .overflow       (overflow),
        .final_res      (final_res)
    );

endmodule

`default_nettype wire
